### rtl/stdr_pkg.sv
// package: shared types and constants for the sparse times dense rows block
`default_nettype none
package stdr_pkg;
	localparam int DimDefault = 1024;
	localparam int EllDefault = 8;
	localparam int RowW = 16;
	localparam int ColW = 10;
	localparam int LaneW = 3;
	localparam int ValW = 32;
	localparam int SumW = 48;
	localparam int AccW = 64;
	localparam int LastW = 3;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_NZ   = 1'b1
	} cmd_t;

	typedef struct packed {
		logic                   command;
		logic [RowW-1:0]        row_index;
		logic [ColW-1:0]        col_index;
		logic [LaneW-1:0]       lane;
		logic signed [ValW-1:0] value;
		logic                   row_end;
	} in_item_t;

	typedef struct packed {
		logic [RowW-1:0]        out_row;
		logic [LaneW-1:0]       out_lane;
		logic signed [SumW-1:0] sum;
		logic                   saturated;
		logic [LastW-1:0]       last;
	} out_item_t;

	// work passed from front to back
	typedef struct packed {
		logic                   is_load;
		logic                   col_ok;
		logic                   row_end;
		logic [RowW-1:0]        row;
		logic [ColW-1:0]        col;
		logic [LaneW-1:0]       lane;
		logic signed [ValW-1:0] value;
	} op_t;
endpackage
`default_nettype wire

### rtl/stdr_front.sv
// front: accepts transactions, classifies them and queues them for the back end
`default_nettype none
module stdr_front #(
	parameter int DIM   = stdr_pkg::DimDefault,
	parameter int ELL   = stdr_pkg::EllDefault,
	parameter int DEPTH = 2
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  stdr_pkg::in_item_t   in_data,
	input  wire                  in_valid,
	output logic                 in_ready,
	output stdr_pkg::op_t        op_data,
	output logic                 op_valid,
	input  wire                  op_ready
);
	import stdr_pkg::*;
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	op_t          fifo_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	op_t          op_in;
	logic         push, pop;

	always_comb begin
		op_in.is_load = (in_data.command == CMD_LOAD);
		op_in.col_ok  = (32'(in_data.col_index) < 32'(DIM));
		// loads to a lane past the last are dropped at the back
		if (in_data.command == CMD_LOAD)
			op_in.col_ok = op_in.col_ok && (32'(in_data.lane) < 32'(ELL));
		op_in.row_end = in_data.row_end && (in_data.command == CMD_NZ);
		op_in.row     = in_data.row_index;
		op_in.col     = in_data.col_index;
		op_in.lane    = in_data.lane;
		op_in.value   = in_data.value;
	end

	assign in_ready = (cnt_q != (PW+1)'(DEPTH));
	assign op_valid = (cnt_q != '0);
	assign op_data  = fifo_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = op_valid && op_ready;

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_q] <= op_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (32'(wr_q) == DEPTH-1) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (32'(rd_q) == DEPTH-1) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

### rtl/stdr_back.sv
// back: dense store, lane-serial multiply-accumulate and row emission
`default_nettype none
module stdr_back #(
	parameter int DIM = stdr_pkg::DimDefault,
	parameter int ELL = stdr_pkg::EllDefault
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  stdr_pkg::op_t        op_data,
	input  wire                  op_valid,
	output logic                 op_ready,
	output stdr_pkg::out_item_t  out_data,
	output logic                 out_valid,
	input  wire                  out_ready
);
	import stdr_pkg::*;
	localparam int LW    = (ELL > 1) ? $clog2(ELL) : 1;
	localparam int DEP   = DIM * ELL;
	localparam int AW    = (DEP > 1) ? $clog2(DEP) : 1;
	localparam int DW    = (DIM > 1) ? $clog2(DIM) : 1;
	localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
	localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
	localparam logic signed [AccW-1:0] SatMax = AccW'({1'b0, {(SumW-1){1'b1}}});
	localparam logic signed [AccW-1:0] SatMin = -SatMax - AccW'(1);

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_MUL, S_ACC, S_EMIT
	} state_t;

	logic [ValW-1:0]        mem [DEP];
	logic signed [ValW-1:0] g_s1;
	logic signed [AccW-1:0] prod_s2;
	logic signed [AccW-1:0] acc_q [ELL];
	state_t                 state_q;
	logic [LW-1:0]          lane_q;
	op_t                    op_q;
	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          wr_addr;
	logic signed [AccW-1:0] cur, shifted, acc_sum, acc_nx, emit_v;
	logic                   emit_sat;
	logic                   last_lane;
	logic                   emit_fire;

	assign op_ready  = (state_q == S_IDLE);
	assign last_lane = (32'(lane_q) == ELL-1);
	assign rd_addr   = AW'(32'(op_q.col[DW-1:0]) * ELL + 32'(lane_q));
	assign wr_addr   = AW'(32'(op_data.col[DW-1:0]) * ELL + 32'(op_data.lane));
	// one result leaves per cycle while the output register is free or being taken
	assign emit_fire = (state_q == S_EMIT) && (!out_valid || out_ready);

	always_ff @(posedge clk) begin
		if (op_valid && op_ready && op_data.is_load && op_data.col_ok)
			mem[wr_addr] <= op_data.value;
		g_s1 <= $signed(mem[rd_addr]);
	end

	always_ff @(posedge clk) begin
		prod_s2 <= AccW'(op_q.value) * AccW'(g_s1);
	end

	always_comb begin
		cur     = acc_q[lane_q];
		shifted = prod_s2 >>> 16;
		acc_sum = cur + shifted;
		acc_nx  = acc_sum;
		if (!shifted[AccW-1] && !cur[AccW-1] && acc_sum[AccW-1])
			acc_nx = AccMax;
		else if (shifted[AccW-1] && cur[AccW-1] && !acc_sum[AccW-1])
			acc_nx = AccMin;
		emit_v   = cur;
		emit_sat = 1'b0;
		if (cur > SatMax) begin
			emit_v   = SatMax;
			emit_sat = 1'b1;
		end else if (cur < SatMin) begin
			emit_v   = SatMin;
			emit_sat = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			lane_q    <= '0;
			out_valid <= 1'b0;
			op_q      <= '0;
			out_data  <= '0;
			for (int i = 0; i < ELL; i++)
				acc_q[i] <= '0;
		end else begin
			if (emit_fire)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (op_valid) begin
						op_q   <= op_data;
						lane_q <= '0;
						if (op_data.is_load)
							state_q <= S_IDLE;
						else if (op_data.col_ok)
							state_q <= S_READ;
						else if (op_data.row_end)
							state_q <= S_EMIT;
					end
				end
				S_READ: state_q <= S_MUL;
				S_MUL:  state_q <= S_ACC;
				S_ACC: begin
					acc_q[lane_q] <= acc_nx;
					if (last_lane) begin
						lane_q  <= '0;
						state_q <= op_q.row_end ? S_EMIT : S_IDLE;
					end else begin
						lane_q  <= lane_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_EMIT: begin
					if (emit_fire) begin
						out_data.out_row   <= op_q.row;
						out_data.out_lane  <= LaneW'(lane_q);
						out_data.sum       <= emit_v[SumW-1:0];
						out_data.saturated <= emit_sat;
						out_data.last      <= LastW'(last_lane);
						acc_q[lane_q]      <= '0;
						if (last_lane) begin
							lane_q  <= '0;
							state_q <= S_IDLE;
						end else
							lane_q <= lane_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/sparse_times_dense_rows.sv
// top level: sparse (coordinate rows) times dense matrix product
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | stdr_pkg::in_item_t
// out     | output    | out_valid / out_ready| stdr_pkg::out_item_t
//
// a load is taken by the back end in its idle state and written to the store; a nonzero is taken,
// then read, multiplied and accumulated lane by lane through the single read port and multiplier
// a row end adds an emit step per lane, one result transaction each
// reset clears accumulators and control; the dense store is not cleared
// the front queue keeps accepting while the back end works or the output stalls, until it is full
`default_nettype none
module sparse_times_dense_rows #(
	parameter int DIM = stdr_pkg::DimDefault,
	parameter int ELL = stdr_pkg::EllDefault
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  stdr_pkg::in_item_t  in_data,
	input  wire                 in_valid,
	output logic                in_ready,
	output stdr_pkg::out_item_t out_data,
	output logic                out_valid,
	input  wire                 out_ready
);
	import stdr_pkg::*;

	// classified work between front and back
	op_t  op_data;
	logic op_valid, op_ready;

	stdr_front #(.DIM(DIM), .ELL(ELL)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
		.op_data(op_data), .op_valid(op_valid), .op_ready(op_ready)
	);

	stdr_back #(.DIM(DIM), .ELL(ELL)) u_back (
		.clk(clk), .arst_n(arst_n),
		.op_data(op_data), .op_valid(op_valid), .op_ready(op_ready),
		.out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
	);

	// a held result must not change before it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	// last flag only on the final lane
	a_last_lane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last != '0 |-> 32'(out_data.out_lane) == ((ELL-1) % 8))
		else $error("last on wrong lane");

	// a saturated result sits at one of the range limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
		(out_data.sum[SumW-1] != out_data.sum[SumW-2]) ||
		(out_data.sum[SumW-2:0] == '1) || (out_data.sum[SumW-2:0] == '0))
		else $error("saturated flag without limit value");
endmodule
`default_nettype wire
